// ----- rtl/core/timed_event_queue_assert.svh -----
// Assertion macros for the timed event queue RTL, used by the sequencer.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef TIMED_EVENT_QUEUE_ASSERT_SVH
`define TIMED_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TEQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timed_event_queue: check failed");

// Next-cycle implication, checked out of reset.
`define TEQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timed_event_queue: check failed");

`endif

// ----- rtl/core/teq_pkg.sv -----
// Shared types, sizes and pointer helpers for the timed event queue.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package teq_pkg;

    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 32;
    localparam int TAG_BITS  = 16;
    localparam int PTR_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int SUM_BITS  = CNT_BITS + 1;

    localparam logic OP_POST = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [PTR_BITS-1:0]  ptr_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;
    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [TAG_BITS-1:0]  tag_t;

    typedef struct packed {
        time_t due_time;
        tag_t  tag;
    } entry_t;

    typedef struct packed {
        logic  opcode;
        time_t event_time;
        tag_t  event_tag;
        time_t now_time;
    } in_word_t;

    typedef struct packed {
        logic  fired;
        tag_t  fired_tag;
        time_t fired_time;
        logic  last;
        cnt_t  queued_count;
        logic  overflow;
    } out_word_t;

    typedef struct packed {
        logic   we;
        ptr_t   waddr;
        entry_t wdata;
        ptr_t   raddr;
    } mem_req_t;

    // Address of the entry off places after base, wrapping round the ring.
    function automatic ptr_t slot_addr(ptr_t base, cnt_t off);
        logic [SUM_BITS-1:0] sum;
        sum = {{(SUM_BITS-PTR_BITS){1'b0}}, base} + {1'b0, off};
        if (sum >= SUM_BITS'(DEPTH))
            sum = sum - SUM_BITS'(DEPTH);
        return sum[PTR_BITS-1:0];
    endfunction

    function automatic ptr_t ptr_inc(ptr_t base);
        ptr_t res;
        if (base == PTR_BITS'(DEPTH - 1))
            res = '0;
        else
            res = base + 1'b1;
        return res;
    endfunction

endpackage

// ----- rtl/core/timed_event_queue.sv -----
// Timed event queue: keeps pending events sorted by due time, FIFO among equal times.
//
// Input channel (in_valid / in_stall / in_word): a post word queues an event, or
// dispatches it at once when it is due and earlier than every queued event; a tick
// word dispatches every queued event due by now_time, in order.
// Output channel (out_valid / out_stall / out_word): a post gives one word; a tick
// gives one word per dispatched event, last marking the final one, or a single
// word with fired low when nothing is due. A post into a full queue that is not
// dispatched is dropped with overflow set.
// Sequence: a post that fires, is dropped or lands in an empty queue goes through the
// due check, the head check and the emit state; any other post first walks back from
// the tail past each queued event later than it, one entry per cycle. A post's word
// enters the output register as the sequencer returns to idle. A tick pops each due
// event from the head in order, holding it until the next head is checked; words then
// follow one per cycle while the receiver does not stall.
// in_stall is high from acceptance until the last word enters the output register.
// Reset clears the queue to empty; storage is not cleared. When the receiver
// stalls, the output word holds and the sequencer waits on the next word.
// Depends on teq_pkg, teq_seq and teq_store.
`timescale 1ns / 1ps

module timed_event_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  teq_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output teq_pkg::out_word_t out_word
);
    import teq_pkg::*;

    mem_req_t  mem_req;
    entry_t    rd_data;
    logic      out_free;
    logic      out_load;
    out_word_t out_next;

    logic      out_valid_reg;
    out_word_t out_word_reg;

    teq_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .mem_req  (mem_req),
        .rd_data  (rd_data),
        .out_free (out_free),
        .out_load (out_load),
        .out_next (out_next)
    );

    teq_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Hold the word while stalled.
    always_ff @(posedge clk)
    begin
        if (out_load)
            out_word_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- rtl/core/teq_store.sv -----
// Event storage ring: one write port, one registered read port.
// Depends on teq_pkg.
`timescale 1ns / 1ps

module teq_store (
    input  logic              clk,
    input  teq_pkg::mem_req_t req,
    output teq_pkg::entry_t   rd_data
);
    import teq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.waddr] <= req.wdata;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/teq_seq.sv -----
// Sequencer for post and tick words, built around one shared time comparator.
// Depends on teq_pkg, teq_store (through the request bus) and the assert header.
`timescale 1ns / 1ps
`include "timed_event_queue_assert.svh"

module teq_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  teq_pkg::in_word_t  in_word,
    output teq_pkg::mem_req_t  mem_req,
    input  teq_pkg::entry_t    rd_data,
    input  logic               out_free,
    output logic               out_load,
    output teq_pkg::out_word_t out_next
);
    import teq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PDUE  = 3'd1;
    localparam logic [2:0] S_PHEAD = 3'd2;
    localparam logic [2:0] S_PCMP  = 3'd3;
    localparam logic [2:0] S_PWR0  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_TCHK  = 3'd6;

    logic [2:0] state_reg, state_next;
    ptr_t       head_reg, head_next;
    cnt_t       cnt_reg, cnt_next;
    logic       pend_vld_reg, pend_vld_next;

    time_t      t_reg, t_next;
    tag_t       tag_reg, tag_next;
    time_t      now_reg, now_next;
    cnt_t       j_reg, j_next;
    logic       due_reg, due_next;
    entry_t     pend_reg, pend_next;
    out_word_t  res_reg, res_next;

    time_t      cmp_a, cmp_b;
    logic       cmp_lt;
    logic       hd_due;
    entry_t     new_entry;

    assign new_entry = '{due_time: t_reg, tag: tag_reg};
    assign in_stall  = (state_reg != S_IDLE);

    // Shared comparator: operands picked by the sequencer state.
    always_comb
    begin
        cmp_a = t_reg;
        cmp_b = now_reg;
        case (state_reg)
            S_PDUE:
            begin
                cmp_a = now_reg;
                cmp_b = t_reg;
            end
            S_PHEAD, S_PCMP:
            begin
                cmp_a = t_reg;
                cmp_b = rd_data.due_time;
            end
            S_TCHK:
            begin
                cmp_a = now_reg;
                cmp_b = rd_data.due_time;
            end
            default:
            begin
                cmp_a = t_reg;
                cmp_b = now_reg;
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);
    assign hd_due = (cnt_reg != '0) && !cmp_lt;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        pend_vld_next = pend_vld_reg;
        t_next        = t_reg;
        tag_next      = tag_reg;
        now_next      = now_reg;
        j_next        = j_reg;
        due_next      = due_reg;
        pend_next     = pend_reg;
        res_next      = res_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = slot_addr(head_reg, j_reg);
        mem_req.wdata = new_entry;
        mem_req.raddr = head_reg;
        out_load      = 1'b0;
        out_next      = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    t_next   = in_word.event_time;
                    tag_next = in_word.event_tag;
                    now_next = in_word.now_time;
                    pend_vld_next = 1'b0;
                    if (in_word.opcode == OP_POST)
                        state_next = S_PDUE;
                    else
                        state_next = S_TCHK;
                end
            end

            S_PDUE:
            begin
                due_next   = !cmp_lt;
                state_next = S_PHEAD;
            end

            S_PHEAD:
            begin
                if (due_reg && (cnt_reg == '0 || cmp_lt))
                begin
                    res_next   = '{fired: 1'b1, fired_tag: tag_reg, fired_time: t_reg,
                                   last: 1'b1, queued_count: cnt_reg, overflow: 1'b0};
                    state_next = S_EMIT;
                end
                else if (cnt_reg == CNT_BITS'(DEPTH))
                begin
                    // Full: drop the word.
                    res_next   = '{fired: 1'b0, fired_tag: '0, fired_time: '0,
                                   last: 1'b1, queued_count: cnt_reg, overflow: 1'b1};
                    state_next = S_EMIT;
                end
                else if (cnt_reg == '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = head_reg;
                    cnt_next      = cnt_reg + 1'b1;
                    res_next      = '{fired: 1'b0, fired_tag: '0, fired_time: '0,
                                      last: 1'b1, queued_count: cnt_reg + 1'b1,
                                      overflow: 1'b0};
                    state_next    = S_EMIT;
                end
                else
                begin
                    // Walk back from the tail, one entry per cycle.
                    j_next        = cnt_reg;
                    mem_req.raddr = slot_addr(head_reg, cnt_reg - 1'b1);
                    state_next    = S_PCMP;
                end
            end

            S_PCMP:
            begin
                mem_req.we = 1'b1;
                if (cmp_lt)
                begin
                    // Entry is later than the new one: move it back a slot.
                    mem_req.wdata = rd_data;
                    j_next        = j_reg - 1'b1;
                    if (j_reg == CNT_BITS'(1))
                        state_next = S_PWR0;
                    else
                        mem_req.raddr = slot_addr(head_reg, j_reg - CNT_BITS'(2));
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    res_next   = '{fired: 1'b0, fired_tag: '0, fired_time: '0,
                                   last: 1'b1, queued_count: cnt_reg + 1'b1,
                                   overflow: 1'b0};
                    state_next = S_EMIT;
                end
            end

            S_PWR0:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = head_reg;
                cnt_next      = cnt_reg + 1'b1;
                res_next      = '{fired: 1'b0, fired_tag: '0, fired_time: '0,
                                  last: 1'b1, queued_count: cnt_reg + 1'b1,
                                  overflow: 1'b0};
                state_next    = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_next   = res_reg;
                    state_next = S_IDLE;
                end
            end

            S_TCHK:
            begin
                // Hold the popped head until the next head is checked, so last is known.
                out_next = '{fired: pend_vld_reg, fired_tag: pend_reg.tag,
                             fired_time: pend_reg.due_time, last: !hd_due,
                             queued_count: cnt_reg, overflow: 1'b0};
                if (!pend_vld_reg)
                begin
                    out_next.fired_tag  = '0;
                    out_next.fired_time = '0;
                    out_next.last       = 1'b1;
                end
                if (pend_vld_reg && !out_free)
                begin
                    mem_req.raddr = head_reg;
                end
                else if (hd_due)
                begin
                    out_load      = pend_vld_reg;
                    pend_next     = rd_data;
                    pend_vld_next = 1'b1;
                    head_next     = ptr_inc(head_reg);
                    cnt_next      = cnt_reg - 1'b1;
                    mem_req.raddr = ptr_inc(head_reg);
                end
                else if (out_free)
                begin
                    out_load      = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg    <= t_next;
        tag_reg  <= tag_next;
        now_reg  <= now_next;
        j_reg    <= j_next;
        due_reg  <= due_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    `TEQ_ASSERT_IMP(a_load_free, out_load, out_free)
    `TEQ_ASSERT_IMP(a_we_post, mem_req.we,
        state_reg == S_PHEAD || state_reg == S_PCMP || state_reg == S_PWR0)
    `TEQ_ASSERT_IMP(a_pend_tick, pend_vld_reg, state_reg == S_TCHK)
    `TEQ_ASSERT_NXT(a_cnt_step, 1'b1,
        cnt_reg == $past(cnt_reg) || cnt_reg == $past(cnt_reg) + 1'b1 ||
        cnt_reg == $past(cnt_reg) - 1'b1)
    `TEQ_ASSERT_IMP(a_cnt_max, state_reg == S_IDLE, cnt_reg <= CNT_BITS'(DEPTH))

endmodule

// ----- tb/tb_timed_event_queue.sv -----
// Testbench for timed_event_queue: directed and random post and tick words.
// A scheduler predictor checks every output word in order. Depends on teq_pkg.
`timescale 1ns / 1ps

module tb_timed_event_queue;

    import teq_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int CALM_TAIL      = 20;
    localparam int RANDOM_ITEMS   = 90;
    localparam int SETTLE_CYCLES  = 24;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_word_t  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_word;

    timed_event_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    always #4 clk = ~clk;

    // shadow of the sorted event queue
    time_t sched_time [DEPTH];
    tag_t  sched_tag  [DEPTH];
    int    sched_count = 0;
    int    sched_peak  = 0;

    in_word_t  cmd_words[$];
    out_word_t dispatch_words[$];

    int in_gap      = 0;
    int out_gap     = 0;
    int quiet       = 0;
    int mismatches  = 0;
    int post_count  = 0;
    int tick_count  = 0;
    int now_fired   = 0;
    int dropped     = 0;
    int tick_fired  = 0;

    function automatic void push_dispatch(logic fired, tag_t tag, time_t tm,
                                          logic last, logic ovf);
        out_word_t w;
        w.fired        = fired;
        w.fired_tag    = tag;
        w.fired_time   = tm;
        w.last         = last;
        w.queued_count = cnt_t'(sched_count);
        w.overflow     = ovf;
        dispatch_words.push_back(w);
    endfunction

    function automatic void schedule_step(in_word_t w);
        int    pos;
        int    i;
        int    fired_n;
        time_t ft;
        tag_t  fg;
        if (w.opcode == OP_POST)
        begin
            post_count++;
            if (w.event_time <= w.now_time &&
                (sched_count == 0 || w.event_time < sched_time[0]))
            begin
                now_fired++;
                push_dispatch(1'b1, w.event_tag, w.event_time, 1'b1, 1'b0);
            end
            else if (sched_count >= DEPTH)
            begin
                dropped++;
                push_dispatch(1'b0, '0, '0, 1'b1, 1'b1);
            end
            else
            begin
                // insert after every entry due at or before the new one
                pos = sched_count;
                while (pos > 0 && sched_time[pos-1] > w.event_time)
                    pos--;
                for (i = sched_count; i > pos; i--)
                begin
                    sched_time[i] = sched_time[i-1];
                    sched_tag[i]  = sched_tag[i-1];
                end
                sched_time[pos] = w.event_time;
                sched_tag[pos]  = w.event_tag;
                sched_count++;
                if (sched_count > sched_peak)
                    sched_peak = sched_count;
                push_dispatch(1'b0, '0, '0, 1'b1, 1'b0);
            end
        end
        else
        begin
            tick_count++;
            fired_n = 0;
            while (sched_count > 0 && sched_time[0] <= w.now_time)
            begin
                ft = sched_time[0];
                fg = sched_tag[0];
                for (i = 1; i < sched_count; i++)
                begin
                    sched_time[i-1] = sched_time[i];
                    sched_tag[i-1]  = sched_tag[i];
                end
                sched_count--;
                fired_n++;
                push_dispatch(1'b1, fg, ft,
                              !(sched_count > 0 && sched_time[0] <= w.now_time), 1'b0);
            end
            tick_fired += fired_n;
            if (fired_n == 0)
                push_dispatch(1'b0, '0, '0, 1'b1, 1'b0);
        end
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    function automatic void add_post(time_t t, tag_t tag, time_t now);
        in_word_t w;
        w.opcode     = OP_POST;
        w.event_time = t;
        w.event_tag  = tag;
        w.now_time   = now;
        cmd_words.push_back(w);
    endfunction

    // tick words carry random junk in the ignored fields
    function automatic void add_tick(time_t now);
        in_word_t w;
        w.opcode     = OP_TICK;
        w.event_time = $urandom;
        w.event_tag  = tag_t'($urandom);
        w.now_time   = now;
        cmd_words.push_back(w);
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word  <= '0;
            in_gap   <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                schedule_step(in_word);
            if (in_gap > 0)
            begin
                in_gap   <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (cmd_words.size() > 0)
            begin
                in_word  <= cmd_words.pop_front();
                in_valid <= 1'b1;
                if (cmd_words.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
                    in_gap <= $urandom_range(1, 19);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (dispatch_words.size() == 0)
                begin
                    $error("unexpected output word %h", out_word);
                    mismatches++;
                end
                else
                begin
                    check_field("fired", dispatch_words[0].fired, out_word.fired);
                    check_field("fired_tag", dispatch_words[0].fired_tag,
                                out_word.fired_tag);
                    check_field("fired_time", dispatch_words[0].fired_time,
                                out_word.fired_time);
                    check_field("last", dispatch_words[0].last, out_word.last);
                    check_field("queued_count", dispatch_words[0].queued_count,
                                out_word.queued_count);
                    check_field("overflow", dispatch_words[0].overflow,
                                out_word.overflow);
                    void'(dispatch_words.pop_front());
                end
            end
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (cmd_words.size() > CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                out_gap   <= $urandom_range(0, 18);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // end the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet <= 0;
            else if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("tb_timed_event_queue NOT OK");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        int    j;
        int    n;
        int    made;
        time_t base;
        time_t t;

        // empty queue, extremes, ordering and ties
        add_tick(32'd0);
        add_post(32'd0, 16'h0000, 32'd0);
        add_post('1, 16'hFFFF, '1);
        add_post(32'd100, 16'd1, 32'd50);
        add_post(32'd100, 16'd2, 32'd200);     // due but equal to head: queue it
        add_post(32'd50, 16'd3, 32'd60);       // due and earliest: fire now
        add_post(32'd80, 16'd4, 32'd10);
        add_post(32'd100, 16'd5, 32'd0);
        for (j = 0; j < 12; j++)
            add_post(32'd90 + time_t'((j / 3) * 7), tag_t'(16'h0100 + j), 32'd0);
        // queue is full now
        add_post(32'd500, 16'hABCD, 32'd0);
        add_post(32'd5, 16'h5555, 32'd5);
        add_post(32'd80, 16'h1234, 32'd90);
        add_tick('1);

        made = 0;
        base = 32'd1000;
        while (made < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
                base = $urandom;
            n = $urandom_range(1, 20);
            for (j = 0; j < n; j++)
            begin
                case ($urandom_range(0, 9))
                    0:       t = $urandom;
                    1, 2:    t = base - time_t'($urandom_range(0, 8));
                    default: t = base + time_t'($urandom_range(0, 24));
                endcase
                add_post(t, tag_t'($urandom),
                         ($urandom_range(0, 9) == 0) ? time_t'($urandom) : base);
            end
            add_tick(base + time_t'($urandom_range(0, 30)));
            made += n + 1;
            case ($urandom_range(0, 5))
                0:
                begin
                    add_tick('1);
                    made++;
                end
                1:
                begin
                    add_tick($urandom);
                    made++;
                end
                default: ;
            endcase
            base += time_t'($urandom_range(5, 40));
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_words.size() != 0 || in_valid)
            @(posedge clk);
        while (dispatch_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("posts: %0d (%0d fired at once, %0d dropped on a full queue), ticks: %0d",
                 post_count, now_fired, dropped, tick_count);
        $display("events fired by ticks: %0d, deepest queue: %0d, mismatches: %0d",
                 tick_fired, sched_peak, mismatches);
        if (mismatches == 0)
            $display("tb_timed_event_queue OK");
        else
            $display("tb_timed_event_queue NOT OK");
        $finish;
    end

endmodule
